### design/sha_pkg.sv
package sha_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;
    localparam int unsigned BlockWords = 16;

    typedef logic [WordW-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_byte;
        logic load_pad;
        logic load_len;
        logic start_rounds;
        logic do_round;
        logic fold;
        logic reset_chain;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic block_full;
        logic pad_two;
        logic rounds_done;
    } status_t;

    localparam word_t InitWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadMarker = 8'h80;

    function automatic word_t ror(input word_t v, input int unsigned n);
        return (v >> n) | (v << (WordW - n));
    endfunction

endpackage

### design/sha_if.sv
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### design/sha_datapath.sv
module sha_datapath
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic [7:0] msg_byte,
    output status_t    status,
    output word_t      digest [8]
);

    word_t       w_reg [BlockWords];
    word_t       w_next [BlockWords];
    word_t       h_reg [8];
    word_t       v_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;

    word_t s0, s1, w_new, big0, big1, ch, mj, t1, t2;
    word_t ins_word;
    logic [3:0] widx;
    logic [1:0] bidx;

    assign widx = fill_reg[5:2];
    assign bidx = fill_reg[1:0];

    always_comb
    begin
        s0    = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = s1 + w_reg[9] + s0 + w_reg[0];
        big1  = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
        ch    = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1    = v_reg[7] + big1 + ch + RoundK[rnd_reg] + w_reg[0];
        big0  = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
        mj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2    = big0 + mj;
    end

    always_comb
    begin
        ins_word = w_reg[widx];
        if (cmd.load_byte)
        begin
            ins_word[8*(3-bidx) +: 8] = msg_byte;
        end
        else
        begin
            ins_word[8*(3-bidx) +: 8] = PadMarker;
        end
        unique case (bidx)
            2'd0: ins_word[23:0] = 24'd0;
            2'd1: ins_word[15:0] = 16'd0;
            2'd2: ins_word[7:0]  = 8'd0;
            default: ;
        endcase
        if (cmd.load_byte)
        begin
            ins_word = w_reg[widx];
            ins_word[8*(3-bidx) +: 8] = msg_byte;
        end
    end

    always_comb
    begin
        for (int i = 0; i < BlockWords; i++)
        begin
            w_next[i] = w_reg[i];
        end
        if (cmd.do_round)
        begin
            for (int i = 0; i < BlockWords - 1; i++)
            begin
                w_next[i] = w_reg[i+1];
            end
            w_next[BlockWords-1] = w_new;
        end
        else if (cmd.load_byte)
        begin
            w_next[widx] = ins_word;
        end
        else if (cmd.load_pad || cmd.load_len)
        begin
            if (cmd.load_pad)
            begin
                for (int i = 0; i < BlockWords; i++)
                begin
                    if (4'(i) > widx)
                    begin
                        w_next[i] = '0;
                    end
                end
                w_next[widx] = ins_word;
            end
            else
            begin
                for (int i = 0; i < BlockWords - 2; i++)
                begin
                    w_next[i] = '0;
                end
            end
            if (cmd.load_len)
            begin
                w_next[14] = len_reg[63:32];
                w_next[15] = len_reg[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BlockWords; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitWords[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_byte)
            begin
                fill_reg <= fill_reg + 6'd1;
                len_reg  <= len_reg + 64'd8;
            end
            if (cmd.start_rounds)
            begin
                rnd_reg <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= h_reg[i];
                end
            end
            else if (cmd.do_round)
            begin
                rnd_reg  <= rnd_reg + 6'd1;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            if (cmd.fold)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= h_reg[i] + v_reg[i];
                end
            end
            if (cmd.reset_chain)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < 8; i++)
                begin
                    h_reg[i] <= InitWords[i];
                end
            end
        end
    end

    assign status.block_full  = (fill_reg == 6'd63);
    assign status.pad_two     = (fill_reg >= 6'd56);
    assign status.rounds_done = (rnd_reg == 6'(Rounds - 1));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            digest[i] = h_reg[i];
        end
    end

endmodule

### design/sha_ctrl.sv
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    has_byte,
    input  logic    end_of_message,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd,
    input  logic    emit_done
);

    state_t state_reg, state_next;
    logic   after_reg, after_next;
    logic   eom_reg, eom_next;
    logic   len_reg, len_next;
    logic   accept;

    assign accept = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        eom_next   = eom_reg;
        len_next   = len_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    eom_next   = end_of_message;
                    len_next   = 1'b0;
                    after_next = 1'b0;
                    if (has_byte && status.block_full)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (end_of_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                state_next = ST_ROUND;
                after_next = 1'b1;
                len_next   = after_reg || !status.pad_two;
            end
            ST_ROUND:
            begin
                if (status.rounds_done)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!eom_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (len_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_PAD;
                end
            end
            ST_EMIT:
            begin
                if (emit_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_byte = accept && has_byte;
                cmd.start_rounds = accept && has_byte && status.block_full;
            end
            ST_PAD:
            begin
                if (!after_reg)
                begin
                    cmd.load_pad = 1'b1;
                end
                if (after_reg || !status.pad_two)
                begin
                    cmd.load_len = 1'b1;
                end
                cmd.start_rounds = 1'b1;
            end
            ST_ROUND: cmd.do_round = 1'b1;
            ST_FOLD:
            begin
                cmd.fold      = 1'b1;
                cmd.emit_load = eom_reg && len_reg;
            end
            ST_EMIT: cmd.reset_chain = emit_done;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= 1'b0;
            eom_reg   <= 1'b0;
            len_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            eom_reg   <= eom_next;
            len_reg   <= len_next;
        end
    end

endmodule

### design/sha_emit.sv
module sha_emit
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  word_t digest [8],
    sha_out_if.source dout,
    output logic done
);

    logic       busy_reg;
    logic [2:0] idx_reg;
    logic       fire;

    assign fire             = dout.valid && dout.ready;
    assign dout.valid       = busy_reg;
    assign dout.digest_word = digest[idx_reg];
    assign dout.word_index  = idx_reg;
    assign dout.last_word   = (idx_reg == 3'd7);
    assign done             = fire && dout.last_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (fire)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

### design/sha256_byte_stream_hash.sv
// A byte that fills a block starts a compression; other bytes are only stored.
// Message end: one or two compressions, then eight digest beats.
// Throughput is set by the single shared round unit, one round per cycle.
// Bytes are not accepted while a block is compressed or the digest is emitted.
// Reset: rst_n asynchronously loads the initial hash and clears all control.
module sha256_byte_stream_hash
    import sha_pkg::*;
(
    input logic clk,
    input logic rst_n,
    sha_in_if.sink    din,
    sha_out_if.source dout
);

    cmd_t    cmd;
    status_t status;
    word_t   digest [8];
    logic    emit_done;

    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (din.valid),
        .has_byte       (din.has_byte),
        .end_of_message (din.end_of_message),
        .in_ready       (din.ready),
        .status         (status),
        .cmd            (cmd),
        .emit_done      (emit_done)
    );

    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .msg_byte (din.msg_byte),
        .status   (status),
        .digest   (digest)
    );

    sha_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.emit_load),
        .digest (digest),
        .dout   (dout),
        .done   (emit_done)
    );

endmodule
